// ===== rtl/core/pccd_pkg.sv =====
`default_nettype none
package pccd_pkg;

	// request type codes
	localparam logic REQ_BUTTON = 1'b0;
	localparam logic REQ_MOTION = 1'b1;

	// button action codes
	localparam logic [1:0] ACT_RELEASE = 2'd0;
	localparam logic [1:0] ACT_PRESS   = 2'd1;
	localparam logic [1:0] ACT_REPEAT  = 2'd2;

	// event kinds
	localparam logic EV_CLICK = 1'b0;
	localparam logic EV_DRAG  = 1'b1;

	localparam int          POS_W     = 16;
	localparam int          THR_W     = 12;
	localparam int          BTN_W     = 3;
	localparam logic [11:0] THR_RESET = 12'd160;   // 10 px in Q8.4

	// controller -> datapath
	typedef struct packed {
		logic cap;          // latch the incoming request
		logic press;        // arm addressed button
		logic release_btn;  // disarm addressed button
		logic emit_click;   // load click event into output register
		logic thr_load;     // square threshold, clear scan index and pending drag
		logic diff;         // absolute deltas for scanned button
		logic sqx;          // square of |dx|
		logic sqy;          // keep dx^2, square |dy|
		logic cmp;          // threshold test, promote to dragging on hit
		logic push;         // flush pending drag (not last), pend scanned button
		logic adv;          // next button
		logic emit_final;   // flush pending drag as last event
		logic upd_last;     // commit new pointer position
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       btn_ok;
		logic [1:0] act;
		logic       click_at;
		logic       drag_at;
		logic       idx_last;
		logic       pend_valid;
		logic       out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/pccd_ctrl.sv =====
`default_nettype none
module pccd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_req_type,
	output logic               in_ready,
	input  wire pccd_pkg::sts_t sts,
	output pccd_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_BTN, ST_THR, ST_SCAN, ST_DIFF,
		ST_SQX, ST_SQY, ST_CMP, ST_CHK, ST_FIN
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap   = 1'b1;
					state_nxt = (in_req_type == pccd_pkg::REQ_MOTION) ? ST_THR : ST_BTN;
				end
			end
			ST_BTN: begin
				state_nxt = ST_IDLE;
				if (sts.btn_ok) begin
					unique case (sts.act)
						pccd_pkg::ACT_PRESS: begin
							cmd.press = 1'b1;
						end
						pccd_pkg::ACT_RELEASE: begin
							if (sts.click_at) begin
								if (sts.out_free) begin
									cmd.emit_click  = 1'b1;
									cmd.release_btn = 1'b1;
								end else begin
									state_nxt = ST_BTN;
								end
							end else begin
								cmd.release_btn = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_THR: begin
				cmd.thr_load = 1'b1;
				state_nxt    = ST_SCAN;
			end
			ST_SCAN: begin
				state_nxt = sts.click_at ? ST_DIFF : ST_CHK;
			end
			ST_DIFF: begin
				cmd.diff  = 1'b1;
				state_nxt = ST_SQX;
			end
			ST_SQX: begin
				cmd.sqx   = 1'b1;
				state_nxt = ST_SQY;
			end
			ST_SQY: begin
				cmd.sqy   = 1'b1;
				state_nxt = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp   = 1'b1;
				state_nxt = ST_CHK;
			end
			ST_CHK: begin
				if (!(sts.drag_at && sts.pend_valid && !sts.out_free)) begin
					cmd.push = sts.drag_at;
					if (sts.idx_last) begin
						state_nxt = ST_FIN;
					end else begin
						cmd.adv   = 1'b1;
						state_nxt = ST_SCAN;
					end
				end
			end
			ST_FIN: begin
				if (!sts.pend_valid) begin
					cmd.upd_last = 1'b1;
					state_nxt    = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.emit_final = 1'b1;
					cmd.upd_last   = 1'b1;
					state_nxt      = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/pccd_datapath.sv =====
`default_nettype none
module pccd_datapath #(
	parameter int NB = 8,
	parameter int IW = 3
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pccd_pkg::cmd_t     cmd,
	output pccd_pkg::sts_t          sts,
	input  wire logic               in_req_type,
	input  wire logic [2:0]         in_button,
	input  wire logic [1:0]         in_action,
	input  wire logic signed [15:0] in_pos_x,
	input  wire logic signed [15:0] in_pos_y,
	input  wire logic               cfg_we,
	input  wire logic [11:0]        cfg_wdata,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    out_kind,
	output logic [2:0]              out_button,
	output logic signed [15:0]      out_from_x,
	output logic signed [15:0]      out_from_y,
	output logic signed [15:0]      out_to_x,
	output logic signed [15:0]      out_to_y,
	output logic                    out_last
);

	// request
	logic               req_type_q;
	logic [2:0]         button_q;
	logic [1:0]         action_q;
	logic signed [15:0] nx_q, ny_q;

	// state
	logic [11:0]        thr_q;
	logic [NB-1:0]      clicking_q, dragging_q;
	logic signed [15:0] press_x_q [NB];
	logic signed [15:0] press_y_q [NB];
	logic signed [15:0] last_x_q, last_y_q;

	// scan
	logic [IW-1:0]      idx_q, pend_q;
	logic               pend_valid_q;
	logic [23:0]        thr2_q;
	logic [15:0]        adx_q, ady_q;
	logic [31:0]        prod_q, sum_q;

	logic               out_valid_q;

	logic [IW-1:0]      rd_idx;
	logic signed [16:0] dx, dy;
	logic [15:0]        mul_op;
	logic [31:0]        mul_res;
	logic [32:0]        dist2;
	logic               hit;
	logic               load_out;

	assign rd_idx  = (req_type_q == pccd_pkg::REQ_MOTION) ? idx_q : button_q[IW-1:0];
	assign dx      = {nx_q[15], nx_q} - {press_x_q[rd_idx][15], press_x_q[rd_idx]};
	assign dy      = {ny_q[15], ny_q} - {press_y_q[rd_idx][15], press_y_q[rd_idx]};
	assign mul_op  = cmd.sqx ? adx_q : ady_q;
	assign mul_res = {16'd0, mul_op} * {16'd0, mul_op};
	assign dist2   = {1'b0, sum_q} + {1'b0, prod_q};
	assign hit     = dist2 >= {9'd0, thr2_q};

	assign load_out = cmd.emit_click | (cmd.push & pend_valid_q) | cmd.emit_final;

	assign sts.btn_ok     = {1'b0, button_q} < 4'(NB);
	assign sts.act        = action_q;
	assign sts.click_at   = clicking_q[rd_idx];
	assign sts.drag_at    = dragging_q[rd_idx];
	assign sts.idx_last   = idx_q == IW'(NB - 1);
	assign sts.pend_valid = pend_valid_q;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q        <= pccd_pkg::THR_RESET;
			clicking_q   <= '0;
			dragging_q   <= '0;
			last_x_q     <= '0;
			last_y_q     <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < NB; i++) begin
				press_x_q[i] <= '0;
				press_y_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (cmd.press) begin
				clicking_q[rd_idx] <= 1'b1;
				dragging_q[rd_idx] <= 1'b0;
				press_x_q[rd_idx]  <= last_x_q;
				press_y_q[rd_idx]  <= last_y_q;
			end
			if (cmd.release_btn) begin
				clicking_q[rd_idx] <= 1'b0;
				dragging_q[rd_idx] <= 1'b0;
			end
			if (cmd.cmp && hit) begin
				clicking_q[rd_idx] <= 1'b0;
				dragging_q[rd_idx] <= 1'b1;
			end
			if (cmd.thr_load) begin
				pend_valid_q <= 1'b0;
			end else if (cmd.push) begin
				pend_valid_q <= 1'b1;
			end
			if (cmd.upd_last) begin
				last_x_q <= nx_q;
				last_y_q <= ny_q;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			req_type_q <= in_req_type;
			button_q   <= in_button;
			action_q   <= in_action;
			nx_q       <= in_pos_x;
			ny_q       <= in_pos_y;
		end
		if (cmd.thr_load) begin
			thr2_q <= {12'd0, thr_q} * {12'd0, thr_q};
			idx_q  <= '0;
		end else if (cmd.adv) begin
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.push) begin
			pend_q <= idx_q;
		end
		if (cmd.diff) begin
			adx_q <= dx[16] ? 16'(-dx) : dx[15:0];
			ady_q <= dy[16] ? 16'(-dy) : dy[15:0];
		end
		if (cmd.sqx) begin
			prod_q <= mul_res;
		end
		if (cmd.sqy) begin
			sum_q  <= prod_q;
			prod_q <= mul_res;
		end
		if (cmd.emit_click) begin
			out_kind   <= pccd_pkg::EV_CLICK;
			out_button <= button_q;
			out_from_x <= press_x_q[rd_idx];
			out_from_y <= press_y_q[rd_idx];
			out_to_x   <= '0;
			out_to_y   <= '0;
			out_last   <= 1'b1;
		end else if ((cmd.push && pend_valid_q) || cmd.emit_final) begin
			out_kind   <= pccd_pkg::EV_DRAG;
			out_button <= 3'(pend_q);
			out_from_x <= last_x_q;
			out_from_y <= last_y_q;
			out_to_x   <= nx_q;
			out_to_y   <= ny_q;
			out_last   <= cmd.emit_final;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/pointer_click_drag_classifier.sv =====
`default_nettype none
// Pointer click / drag classifier.
// Input channel (in_valid/in_ready): one pointer request per transfer, either a
// button event (button, action) or a motion (pos_x, pos_y, signed Q12.4).
// Output channel (out_valid/out_ready): click and drag events; last_event marks
// the final event a request produced. A request may produce no event.
// cfg_we/cfg_wdata write drag_threshold (Q8.4 distance); the user must write it
// only while idle, which the block itself does not enforce.
// Timing: one request is processed at a time; in_ready is high only when idle.
// A motion runs a scan loop that walks the buttons through one shared squarer;
// a clicking button goes through difference, square x, square y and compare
// before its drag check, other buttons only through the drag check.
// Results pass through one output register; a request can be accepted while
// the previous event still waits there. When the receiver stalls, the scan
// holds at the next event until the output register frees up.
// Reset: all buttons idle, pointer position zero, drag_threshold = 160 (10 px).
module pointer_click_drag_classifier #(
	parameter int NUM_BUTTONS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               req_type,
	input  wire logic [2:0]         button,
	input  wire logic [1:0]         action,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    event_kind,
	output logic [2:0]              event_button,
	output logic signed [15:0]      from_x,
	output logic signed [15:0]      from_y,
	output logic signed [15:0]      to_x,
	output logic signed [15:0]      to_y,
	output logic                    last_event,
	input  wire logic               cfg_we,
	input  wire logic [11:0]        cfg_wdata
);

	// only 3-bit button indexes exist, so at most eight slots
	localparam int NB = (NUM_BUTTONS < 8) ? NUM_BUTTONS : 8;
	localparam int IW = (NB > 1) ? $clog2(NB) : 1;

	pccd_pkg::cmd_t cmd;
	pccd_pkg::sts_t sts;

	pccd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_req_type (req_type),
		.in_ready    (in_ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	pccd_datapath #(
		.NB (NB),
		.IW (IW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_req_type (req_type),
		.in_button   (button),
		.in_action   (action),
		.in_pos_x    (pos_x),
		.in_pos_y    (pos_y),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_kind    (event_kind),
		.out_button  (event_button),
		.out_from_x  (from_x),
		.out_from_y  (from_y),
		.out_to_x    (to_x),
		.out_to_y    (to_y),
		.out_last    (last_event)
	);

endmodule
`default_nettype wire

// ===== rtl/core/pccd_checker.sv =====
`default_nettype none
module pccd_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic               event_kind,
	input wire logic [2:0]         event_button,
	input wire logic signed [15:0] from_x,
	input wire logic signed [15:0] from_y,
	input wire logic signed [15:0] to_x,
	input wire logic signed [15:0] to_y,
	input wire logic               last_event
);

	// stalled event holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_kind) &&
		$stable(event_button) && $stable(from_x) && $stable(from_y) &&
		$stable(to_x) && $stable(to_y) && $stable(last_event))
		else $error("stalled event changed");

	// one request at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after a transfer");

	// a click is always the only event of its request
	a_click_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == pccd_pkg::EV_CLICK |->
		last_event && to_x == 16'sd0 && to_y == 16'sd0)
		else $error("malformed click event");

	// events only come out of request processing
	a_event_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("event appeared while idle");

endmodule

bind pointer_click_drag_classifier pccd_checker u_pccd_checker (.*);
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	localparam logic       REQ_BUTTON  = pccd_pkg::REQ_BUTTON;
	localparam logic       REQ_MOTION  = pccd_pkg::REQ_MOTION;
	localparam logic [1:0] ACT_RELEASE = pccd_pkg::ACT_RELEASE;
	localparam logic [1:0] ACT_PRESS   = pccd_pkg::ACT_PRESS;
	localparam logic [1:0] ACT_REPEAT  = pccd_pkg::ACT_REPEAT;
	localparam logic       EV_CLICK    = pccd_pkg::EV_CLICK;
	localparam logic       EV_DRAG     = pccd_pkg::EV_DRAG;
	localparam logic [11:0] THR_RESET  = pccd_pkg::THR_RESET;

	localparam int NBTN = 8;
	// action code the package leaves unnamed; the block treats it like repeat
	localparam logic [1:0] ACT_UNKNOWN = 2'd3;
	// a motion walks every button, so allow for the whole scan plus overhead
	localparam int SETTLE = 64;
	// cycles with no transfer on either channel before the run is declared hung
	localparam int HANG_LIMIT = 4000;
	localparam int PHASE_ITEMS = 24;

	// how a stimulus row is checked: by the predictor, by a value typed in, or not at all
	typedef enum {CHK_MODEL, CHK_NONE, CHK_CLICK} check_t;

	typedef struct {
		logic               kind;
		logic [2:0]         btn;
		logic signed [15:0] fx, fy, tx, ty;
		logic               last;
	} ev_t;

	typedef struct {
		logic               rq;
		logic [2:0]         b;
		logic [1:0]         a;
		logic signed [15:0] x, y;
		check_t             chk;
		logic signed [15:0] fx, fy;   // typed click: expected press position
	} row_t;

	logic clk;
	logic arst_n = 1'b0;

	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               req_type = REQ_BUTTON;
	logic [2:0]         button   = '0;
	logic [1:0]         action   = ACT_RELEASE;
	logic signed [15:0] pos_x    = '0;
	logic signed [15:0] pos_y    = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               event_kind;
	logic [2:0]         event_button;
	logic signed [15:0] from_x, from_y, to_x, to_y;
	logic               last_event;
	logic               cfg_we    = 1'b0;
	logic [11:0]        cfg_wdata = '0;

	pointer_click_drag_classifier #(
		.NUM_BUTTONS(NBTN)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.button      (button),
		.action      (action),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.event_kind  (event_kind),
		.event_button(event_button),
		.from_x      (from_x),
		.from_y      (from_y),
		.to_x        (to_x),
		.to_y        (to_y),
		.last_event  (last_event),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Gesture predictor: own copy of button flags, press positions,
	// pointer position and threshold.
	// ---------------------------------------------------------------
	logic [NBTN-1:0]    clicking = '0;
	logic [NBTN-1:0]    dragging = '0;
	logic signed [15:0] press_x [NBTN];
	logic signed [15:0] press_y [NBTN];
	logic signed [15:0] ptr_x = '0;
	logic signed [15:0] ptr_y = '0;
	logic [11:0]        drag_thr = THR_RESET;

	ev_t fresh_events[$];      // events caused by the request just accepted
	ev_t pending_events[$];    // events still owed by the block

	int  errors      = 0;
	int  items_sent  = 0;
	int  phase_items = 0;
	int  clicks_seen = 0;
	int  drags_seen  = 0;
	int  max_burst   = 0;
	bit  calm        = 1'b0;  // no gaps or stalls on either side

	initial begin
		for (int i = 0; i < NBTN; i++) begin
			press_x[i] = '0;
			press_y[i] = '0;
		end
	end

	task automatic classify_request(input logic rq, input logic [2:0] b,
			input logic [1:0] a, input logic signed [15:0] nx, input logic signed [15:0] ny);
		longint dx, dy, thr_sq;
		ev_t    ev;
		fresh_events.delete();
		if (rq == REQ_BUTTON) begin
			if (int'(b) < NBTN) begin
				if (a == ACT_PRESS) begin
					// re-arming always restarts the gesture from the current pointer
					clicking[b] = 1'b1;
					dragging[b] = 1'b0;
					press_x[b]  = ptr_x;
					press_y[b]  = ptr_y;
				end else if (a == ACT_RELEASE) begin
					// only a button that never moved far enough reports a click
					if (clicking[b]) begin
						ev = '{EV_CLICK, b, press_x[b], press_y[b], 16'sd0, 16'sd0, 1'b0};
						fresh_events.insert(fresh_events.size(), ev);
					end
					clicking[b] = 1'b0;
					dragging[b] = 1'b0;
				end
			end
		end else begin
			thr_sq = longint'(drag_thr) * longint'(drag_thr);
			for (int i = 0; i < NBTN; i++) begin
				if (clicking[i]) begin
					dx = longint'(nx) - longint'(press_x[i]);
					dy = longint'(ny) - longint'(press_y[i]);
					if (dx * dx + dy * dy >= thr_sq) begin
						clicking[i] = 1'b0;
						dragging[i] = 1'b1;
					end
				end
				if (dragging[i]) begin
					ev = '{EV_DRAG, 3'(i), ptr_x, ptr_y, nx, ny, 1'b0};
					fresh_events.insert(fresh_events.size(), ev);
				end
			end
			ptr_x = nx;
			ptr_y = ny;
		end
		if (fresh_events.size() > 0)
			fresh_events[fresh_events.size() - 1].last = 1'b1;
	endtask

	// ---------------------------------------------------------------
	// Request side
	// ---------------------------------------------------------------
	task automatic send(input row_t r);
		int  gap;
		ev_t ev;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r.rq;
		button   <= r.b;
		action   <= r.a;
		pos_x    <= r.x;
		pos_y    <= r.y;
		do @(posedge clk); while (!in_ready);
		// transfer done at this edge: work out what the block now owes
		classify_request(r.rq, r.b, r.a, r.x, r.y);
		if (fresh_events.size() > max_burst)
			max_burst = fresh_events.size();
		unique case (r.chk)
			CHK_MODEL: foreach (fresh_events[i])
				pending_events.insert(pending_events.size(), fresh_events[i]);
			CHK_CLICK: begin
				ev = '{EV_CLICK, r.b, r.fx, r.fy, 16'sd0, 16'sd0, 1'b1};
				pending_events.insert(pending_events.size(), ev);
			end
			default: ;
		endcase
		items_sent++;
		phase_items++;
	endtask

	// drop valid, let every owed event drain, then give a silent motion time to finish
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_threshold(input logic [11:0] v);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		drag_thr  = v;
	endtask

	function automatic logic signed [15:0] clamp16(input longint v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return 16'(v);
	endfunction

	function automatic row_t button_row(input logic [2:0] b, input logic [1:0] a);
		row_t r;
		r.rq  = REQ_BUTTON;
		r.b   = b;
		r.a   = a;
		r.x   = 16'($urandom);   // ignored by the block on button events
		r.y   = 16'($urandom);
		r.chk = CHK_MODEL;
		r.fx  = '0;
		r.fy  = '0;
		return r;
	endfunction

	// motion aimed relative to the pointer: small jitter, right at the
	// threshold on an axis or the diagonal, or anywhere at all
	function automatic row_t motion_row();
		row_t   r;
		int     reach, jig, mode;
		longint ox, oy, t;
		r     = button_row(3'($urandom), 2'($urandom));
		r.rq  = REQ_MOTION;
		reach = int'(drag_thr);
		jig   = $urandom_range(0, 2);
		jig   = jig - 1;
		mode  = $urandom_range(0, 3);
		ox    = 0;
		oy    = 0;
		unique case (mode)
			0: begin
				ox = $urandom_range(0, reach / 2);
				oy = $urandom_range(0, reach / 2);
			end
			1: ox = reach + jig;
			2: begin
				ox = (reach * 181) / 256 + jig;
				oy = ox;
			end
			default: ;
		endcase
		if (mode != 3) begin
			if ($urandom_range(0, 1)) ox = -ox;
			if ($urandom_range(0, 1)) oy = -oy;
			if ($urandom_range(0, 1)) begin
				t  = ox;
				ox = oy;
				oy = t;
			end
			r.x = clamp16(longint'(ptr_x) + ox);
			r.y = clamp16(longint'(ptr_y) + oy);
		end
		return r;
	endfunction

	task automatic send_noise();
		if ($urandom_range(0, 2) == 0)
			send(motion_row());
		else
			send(button_row(3'($urandom), 2'($urandom)));
	endtask

	// press a set of buttons, move a little or a lot, release in rotated order
	task automatic run_gesture();
		logic [NBTN-1:0] held;
		int              moves, start, k;
		held = NBTN'($urandom_range(1, (1 << NBTN) - 1));
		if ($urandom_range(0, 4) == 0)
			held = '1;
		for (int i = 0; i < NBTN; i++) begin
			if (held[i])
				send(button_row(3'(i), ACT_PRESS));
			if ($urandom_range(0, 9) == 0)
				send_noise();
		end
		moves = $urandom_range(0, 3);
		repeat (moves) send(motion_row());
		start = $urandom_range(0, NBTN - 1);
		for (int j = 0; j < NBTN; j++) begin
			k = (start + j) % NBTN;
			if (held[k])
				send(button_row(3'(k), ACT_RELEASE));
		end
	endtask

	// Directed rows. Button events carry junk positions and motions carry
	// junk button/action to show those fields are ignored.
	row_t script [24] = '{
		// release, repeat, the unnamed action and a motion with no button held: silent
		'{REQ_BUTTON, 3'd0, ACT_RELEASE, 16'sd0,     16'sd0,     CHK_NONE,  16'sd0,     16'sd0},
		'{REQ_BUTTON, 3'd1, ACT_REPEAT,  16'sh7FFF,  16'sh7FFF,  CHK_NONE,  16'sd0,     16'sd0},
		'{REQ_BUTTON, 3'd2, ACT_UNKNOWN, 16'sh8000,  16'sh8000,  CHK_NONE,  16'sd0,     16'sd0},
		'{REQ_MOTION, 3'd7, ACT_PRESS,   16'sd0,     16'sd0,     CHK_NONE,  16'sd0,     16'sd0},
		// plain click at the reset position
		'{REQ_BUTTON, 3'd0, ACT_PRESS,   16'sh5A5A,  16'shA5A5,  CHK_NONE,  16'sd0,     16'sd0},
		'{REQ_BUTTON, 3'd0, ACT_RELEASE, 16'sd0,     16'sd0,     CHK_CLICK, 16'sd0,     16'sd0},
		// move to the corner, click the top button there
		'{REQ_MOTION, 3'd3, ACT_RELEASE, 16'sh7FFF,  16'sh8000,  CHK_NONE,  16'sd0,     16'sd0},
		'{REQ_BUTTON, 3'd7, ACT_PRESS,   16'sd0,     16'sd0,     CHK_NONE,  16'sd0,     16'sd0},
		'{REQ_BUTTON, 3'd7, ACT_RELEASE, 16'sd0,     16'sd0,     CHK_CLICK, 16'sh7FFF,  16'sh8000},
		// two buttons; one step short of the threshold, then exactly on it
		'{REQ_BUTTON, 3'd3, ACT_PRESS,   16'sd0,     16'sd0,     CHK_NONE,  16'sd0,     16'sd0},
		'{REQ_BUTTON, 3'd5, ACT_PRESS,   16'sd0,     16'sd0,     CHK_NONE,  16'sd0,     16'sd0},
		'{REQ_MOTION, 3'd0, ACT_RELEASE, 16'sd32608, 16'sh8000,  CHK_MODEL, 16'sd0,     16'sd0},
		'{REQ_MOTION, 3'd0, ACT_RELEASE, 16'sd32607, 16'sh8000,  CHK_MODEL, 16'sd0,     16'sd0},
		// release of a dragging button is silent
		'{REQ_BUTTON, 3'd3, ACT_RELEASE, 16'sd0,     16'sd0,     CHK_NONE,  16'sd0,     16'sd0},
		'{REQ_MOTION, 3'd0, ACT_RELEASE, 16'sh8000,  16'sh7FFF,  CHK_MODEL, 16'sd0,     16'sd0},
		// press while dragging re-arms as a click from the new spot
		'{REQ_BUTTON, 3'd5, ACT_PRESS,   16'sd0,     16'sd0,     CHK_NONE,  16'sd0,     16'sd0},
		'{REQ_BUTTON, 3'd5, ACT_RELEASE, 16'sd0,     16'sd0,     CHK_CLICK, 16'sh8000,  16'sh7FFF},
		// four buttons dragged across full range twice
		'{REQ_BUTTON, 3'd0, ACT_PRESS,   16'sd0,     16'sd0,     CHK_NONE,  16'sd0,     16'sd0},
		'{REQ_BUTTON, 3'd2, ACT_PRESS,   16'sd0,     16'sd0,     CHK_NONE,  16'sd0,     16'sd0},
		'{REQ_BUTTON, 3'd4, ACT_PRESS,   16'sd0,     16'sd0,     CHK_NONE,  16'sd0,     16'sd0},
		'{REQ_BUTTON, 3'd6, ACT_PRESS,   16'sd0,     16'sd0,     CHK_NONE,  16'sd0,     16'sd0},
		'{REQ_MOTION, 3'd0, ACT_RELEASE, 16'sh8000,  16'sh8000,  CHK_MODEL, 16'sd0,     16'sd0},
		'{REQ_MOTION, 3'd0, ACT_RELEASE, 16'sh7FFF,  16'sh7FFF,  CHK_MODEL, 16'sd0,     16'sd0},
		'{REQ_BUTTON, 3'd6, ACT_RELEASE, 16'sd0,     16'sd0,     CHK_NONE,  16'sd0,     16'sd0}
	};

	initial begin
		logic [11:0] thr_plan [5];
		logic [11:0] thr_now;
		bit          paused;
		paused   = 1'b0;
		// thresholds per phase: zero, max, one, random, back to reset value
		thr_plan = '{12'd0, 12'd4095, 12'd1, 12'd0, THR_RESET};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) send(script[i]);

		for (int ph = 0; ph < 5; ph++) begin
			thr_now = (ph == 3) ? 12'($urandom_range(2, 4094)) : thr_plan[ph];
			set_threshold(thr_now);
			calm        = (ph == 3);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				// hold off mid-phase until the block owes nothing
				if (ph == 1 && phase_items >= PHASE_ITEMS / 2 && !paused) begin
					wait_idle();
					paused = 1'b1;
				end
				if ($urandom_range(0, 9) < 7)
					run_gesture();
				else
					send_noise();
			end
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d requests over thresholds 0, 1, 4095, 160 and a random one",
			items_sent);
		$display("checked %0d clicks and %0d drags, up to %0d events from one request",
			clicks_seen, drags_seen, max_burst);
		if (errors == 0)
			$display("pointer_click_drag_classifier: match");
		else
			$display("pointer_click_drag_classifier: mismatch");
		$finish;
	end

	// ---------------------------------------------------------------
	// Event side: random stall per event, compare against oldest owed
	// ---------------------------------------------------------------
	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	initial begin
		int  stall;
		ev_t want;
		forever begin
			stall = calm ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			// transfer at this edge
			if (pending_events.size() == 0) begin
				$error("event transfer with nothing owed: kind %0d button %0d",
					event_kind, event_button);
				errors++;
			end else begin
				want = pending_events.pop_front();
				check_field("event_kind",   want.kind,    event_kind);
				check_field("event_button", want.btn,     event_button);
				check_field("from_x",       int'(want.fx), int'(from_x));
				check_field("from_y",       int'(want.fy), int'(from_y));
				check_field("to_x",         int'(want.tx), int'(to_x));
				check_field("to_y",         int'(want.ty), int'(to_y));
				check_field("last_event",   want.last,    last_event);
				if (want.kind == EV_CLICK)
					clicks_seen++;
				else
					drags_seen++;
			end
		end
	end

	// hang detector: any transfer on either channel resets the count
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < HANG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("no transfer for %0d cycles, %0d events still owed",
			HANG_LIMIT, pending_events.size());
		$display("pointer_click_drag_classifier: mismatch");
		$finish;
	end

endmodule
